>>> rtl/oesc_pkg.sv
`default_nettype none
package oesc_pkg;

  // defaults for the top-level parameters
  localparam int MAX_LEN_DEF       = 16;
  localparam int EVENT_ID_BITS_DEF = 16;

  // fixed field widths
  localparam int OP_W  = 2;
  localparam int IDX_W = 4;
  localparam int LEN_W = 5;
  localparam int OUT_W = 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // op field codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_OBSERVE = 2'd2;

  // outcome codes
  typedef enum logic [OUT_W-1:0] {
    OUT_WAIT = 2'd0,
    OUT_DONE = 2'd1,
    OUT_FAIL = 2'd2
  } outcome_t;

  // classified command carried through the queue
  typedef enum logic [1:0] {
    CMD_NOP     = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_OBSERVE = 2'd3
  } cmd_t;

  // head of queue as seen by the back part
  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
  } q_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/oesc_ram.sv
`default_nettype none
module oesc_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/oesc_front.sv
`default_nettype none
module oesc_front
  import oesc_pkg::*;
#(
  parameter int MAX_LEN       = MAX_LEN_DEF,
  parameter int EVENT_ID_BITS = EVENT_ID_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          in_op,
  input  wire logic [IDX_W-1:0]         in_entry_index,
  input  wire logic [EVENT_ID_BITS-1:0] in_event_id,
  output q_ctrl_t                       q_head,
  output logic      [EVENT_ID_BITS-1:0] q_ev,
  input  wire logic                     q_take
);

  cmd_t               q_cmd_r [QUEUE_DEPTH];
  logic [IDX_W-1:0]   q_idx_r [QUEUE_DEPTH];
  logic [EVENT_ID_BITS-1:0] q_ev_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               push;
  cmd_t               cmd_in;

  // classify the incoming item; loads outside the table do nothing
  always_comb begin
    unique case (in_op)
      OP_LOAD:    cmd_in = (int'(in_entry_index) < MAX_LEN) ? CMD_LOAD : CMD_NOP;
      OP_RESTART: cmd_in = CMD_RESTART;
      OP_OBSERVE: cmd_in = CMD_OBSERVE;
      default:    cmd_in = CMD_NOP;
    endcase
  end

  assign busy = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (q_take) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !q_take) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && q_take) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd_r[wr_ptr_r] <= cmd_in;
      q_idx_r[wr_ptr_r] <= in_entry_index;
      q_ev_r[wr_ptr_r]  <= in_event_id;
    end
  end

  // head of queue
  assign q_head.valid = (count_r != '0);
  assign q_head.cmd   = q_cmd_r[rd_ptr_r];
  assign q_head.idx   = q_idx_r[rd_ptr_r];
  assign q_ev         = q_ev_r[rd_ptr_r];

  // back never takes from an empty queue
  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> count_r != '0)
    else $error("take from empty queue");

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= QUEUE_DEPTH)
    else $error("queue overflow");

endmodule
`default_nettype wire

>>> rtl/oesc_back.sv
`default_nettype none
module oesc_back
  import oesc_pkg::*;
#(
  parameter  int MAX_LEN       = MAX_LEN_DEF,
  parameter  int EVENT_ID_BITS = EVENT_ID_BITS_DEF,
  localparam int PTR_W         = $clog2(MAX_LEN + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  input  wire logic [LEN_W-1:0]         cfg_seq_length,
  input  wire q_ctrl_t                  q_head,
  input  wire logic [EVENT_ID_BITS-1:0] q_ev,
  output logic                          q_take,
  output logic                          out_strobe,
  output logic      [OUT_W-1:0]         out_outcome,
  output logic      [PTR_W-1:0]         out_progress
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PTR_W-1:0]         ptr_r, ptr_nxt;
  logic [PTR_W-1:0]         scan_r, scan_nxt;
  logic [EVENT_ID_BITS-1:0] ev_r, ev_nxt;
  logic [LEN_W-1:0]         seq_len_r;
  logic                     strobe_r, strobe_nxt;
  outcome_t                 outcome_r, outcome_nxt;
  logic [PTR_W-1:0]         progress_r, progress_nxt;
  logic [PTR_W-1:0]         len_eff;
  logic [PTR_W-1:0]         ptr_plus;
  logic [PTR_W-1:0]         scan_plus;
  logic                     we;
  logic [AW-1:0]            raddr;
  logic [EVENT_ID_BITS-1:0] rdata;

  // length register, clamped to the table size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= '0;
    end else if (cfg_valid) begin
      seq_len_r <= cfg_seq_length;
    end
  end

  assign len_eff   = (int'(seq_len_r) > MAX_LEN) ? PTR_W'(MAX_LEN) : PTR_W'(seq_len_r);
  assign ptr_plus  = ptr_r + PTR_W'(1);
  assign scan_plus = scan_r + PTR_W'(1);

  // sequence table
  oesc_ram #(
    .WIDTH (EVENT_ID_BITS),
    .DEPTH (MAX_LEN)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (AW'(q_head.idx)),
    .wdata   (q_ev),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // sequencer: execute, compare at pointer, then scan consumed entries
  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    scan_nxt     = scan_r;
    ev_nxt       = ev_r;
    strobe_nxt   = 1'b0;
    outcome_nxt  = outcome_r;
    progress_nxt = progress_r;
    q_take       = 1'b0;
    we           = 1'b0;
    raddr        = ptr_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_take       = 1'b1;
          strobe_nxt   = 1'b1;
          outcome_nxt  = OUT_WAIT;
          progress_nxt = ptr_r;
          unique case (q_head.cmd)
            CMD_LOAD: begin
              we = 1'b1;
            end
            CMD_RESTART: begin
              ptr_nxt      = '0;
              progress_nxt = '0;
            end
            CMD_OBSERVE: begin
              if (len_eff == '0 || ptr_r >= len_eff) begin
                outcome_nxt = OUT_FAIL;
              end else begin
                strobe_nxt = 1'b0;
                ev_nxt     = q_ev;
                state_nxt  = ST_CMP;
              end
            end
            CMD_NOP: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        raddr = '0;
        if (rdata == ev_r) begin
          ptr_nxt      = ptr_plus;
          strobe_nxt   = 1'b1;
          outcome_nxt  = (ptr_plus == len_eff) ? OUT_DONE : OUT_WAIT;
          progress_nxt = ptr_plus;
          state_nxt    = ST_IDLE;
        end else if (ptr_r == '0) begin
          strobe_nxt   = 1'b1;
          outcome_nxt  = OUT_FAIL;
          progress_nxt = ptr_r;
          state_nxt    = ST_IDLE;
        end else begin
          scan_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        raddr = scan_plus[AW-1:0];
        if (rdata == ev_r) begin
          strobe_nxt   = 1'b1;
          outcome_nxt  = OUT_WAIT;
          progress_nxt = ptr_r;
          state_nxt    = ST_IDLE;
        end else if (scan_plus == ptr_r) begin
          strobe_nxt   = 1'b1;
          outcome_nxt  = OUT_FAIL;
          progress_nxt = ptr_r;
          state_nxt    = ST_IDLE;
        end else begin
          scan_nxt = scan_plus;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ptr_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    ev_r       <= ev_nxt;
    outcome_r  <= outcome_nxt;
    progress_r <= progress_nxt;
  end

  assign out_strobe   = strobe_r;
  assign out_outcome  = outcome_r;
  assign out_progress = progress_r;

  // a result follows a take or the end of a compare or scan
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(q_take) || $past(state_r == ST_CMP) || $past(state_r == ST_SCAN))
    else $error("result without an item");

  // nothing is taken from the queue while an observe is in flight
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !q_take)
    else $error("take while observe in flight");

  // scan stays below the pointer
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_r < ptr_r)
    else $error("scan past pointer");

  // scanning never moves the pointer
  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |=> ptr_r == $past(ptr_r))
    else $error("pointer moved during scan");

endmodule
`default_nettype wire

>>> rtl/ordered_event_sequence_checker.sv
`default_nettype none
// channel  ports                                        handshake
// ------   -------------------------------------------  ---------------------------
// in       in_op, in_entry_index, in_event_id           start && !busy
// out      out_outcome, out_progress                    out_strobe, one cycle
// cfg      cfg_seq_length                               cfg_valid && cfg_ready
//
// load, restart and unused ops are completed by the back sequencer from idle.
// an observe first compares the entry at the pointer; on a miss past the
// first entry it scans the consumed entries for a repeat. a full or finished
// sequence fails without leaving idle. the single read port of the table sets this.
// a two-entry queue decouples acceptance from execution; busy while full.
// reset is synchronous; the table holds nothing defined until loaded.
// results are never held off by the receiver.
module ordered_event_sequence_checker
  import oesc_pkg::*;
#(
  parameter  int MAX_LEN       = MAX_LEN_DEF,
  parameter  int EVENT_ID_BITS = EVENT_ID_BITS_DEF,
  localparam int PTR_W         = $clog2(MAX_LEN + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          in_op,
  input  wire logic [IDX_W-1:0]         in_entry_index,
  input  wire logic [EVENT_ID_BITS-1:0] in_event_id,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [LEN_W-1:0]         cfg_seq_length,
  output logic                          out_strobe,
  output logic      [OUT_W-1:0]         out_outcome,
  output logic      [PTR_W-1:0]         out_progress
);

  q_ctrl_t                  q_head;
  logic [EVENT_ID_BITS-1:0] q_ev;
  logic                     q_take;

  // length register is always writable
  assign cfg_ready = 1'b1;

  // accept and classify
  oesc_front #(
    .MAX_LEN       (MAX_LEN),
    .EVENT_ID_BITS (EVENT_ID_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_entry_index (in_entry_index),
    .in_event_id    (in_event_id),
    .q_head         (q_head),
    .q_ev           (q_ev),
    .q_take         (q_take)
  );

  // execute against the table
  oesc_back #(
    .MAX_LEN       (MAX_LEN),
    .EVENT_ID_BITS (EVENT_ID_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_seq_length (cfg_seq_length),
    .q_head         (q_head),
    .q_ev           (q_ev),
    .q_take         (q_take),
    .out_strobe     (out_strobe),
    .out_outcome    (out_outcome),
    .out_progress   (out_progress)
  );

endmodule
`default_nettype wire
